// ----- hw/rtl/positional_list_engine_core_assert.svh -----
// assertion helpers shared by the list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ple_pkg.sv -----
`default_nettype none

package ple_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 5;
  localparam int DEPTH_DEF = 16;

  // operation codes carried by an input transaction
  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 3'd0,
    OP_REMOVE_AT    = 3'd1,
    OP_REMOVE_FIRST = 3'd2,
    OP_READ         = 3'd3,
    OP_REVERSE      = 3'd4,
    OP_CLEAR        = 3'd5
  } op_t;

  // per-cycle move broadcast to every cell in the row
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,
    CELL_SHL  = 2'd2
  } cell_mode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/positional_list_engine_core.sv -----
`default_nettype none
`include "positional_list_engine_core_assert.svh"

// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------
// input    | in_valid / in_ready   | operation, position, item
// output   | out_valid / out_ready | read_data, error, length, empty_res
//
// insert, remove, remove first, read, clear and refused operations finish
// in the accept cycle; the result is registered and shows in the next cycle.
// reverse on n > 1 items rotates the cell row one step per cycle; during
// the rotation in_ready is low.
// in_ready also needs the result register free or being taken.
// rst clears the item count and the handshake state; cell contents are kept.

module positional_list_engine_core #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ple_pkg::OP_W-1:0]          operation,
  input  wire logic [ple_pkg::POS_W-1:0]         position,
  input  wire logic signed [ple_pkg::DATA_W-1:0] item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ple_pkg::DATA_W-1:0]      read_data,
  output logic                                   error,
  output logic [ple_pkg::LEN_W-1:0]              length,
  output logic                                   empty_res
);
  import ple_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_REV
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [IW-1:0]     rev_k;

  logic                     acc;
  cell_mode_t               mode;
  logic [IW-1:0]            lo;
  logic [IW-1:0]            hi;
  logic [IW-1:0]            sel;
  logic [IW-1:0]            last_idx;
  logic [IW-1:0]            pos_idx;
  logic [CMPW-1:0]          pos_w;
  logic [CMPW-1:0]          cnt_w;
  logic [CW-1:0]            count_next;
  logic                     err_c;
  logic signed [DATA_W-1:0] rd_c;
  logic                     rev_go;
  logic signed [DATA_W-1:0] load_val;
  logic signed [DATA_W-1:0] bus;
  logic signed [DATA_W-1:0] cell_val [DEPTH];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;
  assign last_idx = IW'(count - CW'(1));
  assign pos_idx  = IW'(position);
  assign pos_w    = CMPW'(position);
  assign cnt_w    = CMPW'(count);

  // operation decode and cell row control
  always_comb begin
    mode       = CELL_HOLD;
    lo         = '0;
    hi         = '0;
    sel        = pos_idx;
    count_next = count;
    err_c      = 1'b0;
    rd_c       = '0;
    rev_go     = 1'b0;
    load_val   = item;
    if (state == S_REV) begin
      // rotate the tail right, last item lands at rev_k
      mode     = CELL_SHR;
      lo       = rev_k;
      hi       = last_idx;
      sel      = last_idx;
      load_val = bus;
    end else if (acc) begin
      case (op_t'(operation))
        OP_INSERT: begin
          if ((pos_w > cnt_w) || (count == CW'(DEPTH))) begin
            err_c = 1'b1;
          end else begin
            mode       = CELL_SHR;
            lo         = pos_idx;
            hi         = IW'(count);
            count_next = count + CW'(1);
          end
        end
        OP_REMOVE_AT: begin
          if (pos_w >= cnt_w) begin
            err_c = 1'b1;
          end else begin
            mode       = CELL_SHL;
            lo         = pos_idx;
            hi         = last_idx;
            count_next = count - CW'(1);
          end
        end
        OP_REMOVE_FIRST: begin
          if (count == '0) begin
            err_c = 1'b1;
          end else begin
            mode       = CELL_SHL;
            lo         = '0;
            hi         = last_idx;
            count_next = count - CW'(1);
          end
        end
        OP_READ: begin
          if (pos_w >= cnt_w) begin
            err_c = 1'b1;
          end else begin
            rd_c = bus;
          end
        end
        OP_REVERSE: begin
          rev_go = (count > CW'(1));
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: err_c = 1'b1;
      endcase
    end
  end

  // row of entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    ple_cell #(
      .IW    (IW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .lo        (lo),
      .hi        (hi),
      .load_val  (load_val),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[g])
    );
  end

  // read bus over the row
  ple_rdbus #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_rdbus (
    .cells (cell_val),
    .sel   (sel),
    .data  (bus)
  );

  // sequencer, length and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rev_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            count <= count_next;
            if (rev_go) begin
              state     <= S_REV;
              rev_k     <= '0;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              read_data <= rd_c;
              error     <= err_c;
              length    <= LEN_W'(count_next);
              empty_res <= (count_next == '0);
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_REV: begin
          rev_k <= rev_k + IW'(1);
          if (rev_k == IW'(count - CW'(2))) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            read_data <= '0;
            error     <= 1'b0;
            length    <= LEN_W'(count);
            empty_res <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `PLE_ASSERT_NOW(a_rev_blocks, state == S_REV, !in_ready && !out_valid, "input taken during reverse")
  `PLE_ASSERT_NEXT(a_clear_len, acc && (operation == OP_CLEAR), count == '0, "clear left items behind")
  `PLE_ASSERT_NOW(a_empty_flag, out_valid, empty_res == (length == '0), "empty flag disagrees with length")
  `PLE_ASSERT_NOW(a_err_data, out_valid && error, read_data == '0, "refused transaction returned data")

endmodule

`default_nettype wire

// ----- hw/rtl/ple_cell.sv -----
`default_nettype none

module ple_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  wire logic                               clk,
  input  wire ple_pkg::cell_mode_t                mode,
  input  wire logic [IW-1:0]                      lo,
  input  wire logic [IW-1:0]                      hi,
  input  wire logic signed [ple_pkg::DATA_W-1:0]  load_val,
  input  wire logic signed [ple_pkg::DATA_W-1:0]  left_val,
  input  wire logic signed [ple_pkg::DATA_W-1:0]  right_val,
  output logic signed [ple_pkg::DATA_W-1:0]       val
);
  import ple_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic signed [DATA_W-1:0] val_next;

  // pick the new content from the broadcast or a neighbor
  always_comb begin
    val_next = val;
    case (mode)
      CELL_SHR: begin
        if (MY_IDX == lo) begin
          val_next = load_val;
        end else if ((MY_IDX > lo) && (MY_IDX <= hi)) begin
          val_next = left_val;
        end
      end
      CELL_SHL: begin
        if ((MY_IDX >= lo) && (MY_IDX < hi)) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ple_rdbus.sv -----
`default_nettype none

module ple_rdbus #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic signed [ple_pkg::DATA_W-1:0] cells [DEPTH],
  input  wire logic [IW-1:0]                     sel,
  output logic signed [ple_pkg::DATA_W-1:0]      data
);
  import ple_pkg::*;

  // each cell drives the shared bus only when selected
  always_comb begin
    data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      data = data | (cells[i] & {DATA_W{sel == IW'(i)}});
    end
  end

endmodule

`default_nettype wire
